### rtl/assert_macros.svh
// Assertion helper macros for the dpi32 execute block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### rtl/dpi32_pkg.sv
// Shared types and encodings for the 32-bit A64 data-processing-immediate block.
// No dependencies; imported by dpi32_exec, dpi32_regfile, top level and testbench.
package dpi32_pkg;

  localparam int unsigned NUM_REGS  = 31;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned HALF_BITS = 16;

  localparam logic [IDX_W-1:0] ZERO_REG    = 5'd31;
  localparam logic [3:0]       FLAGS_RESET = 4'b0100;

  // bits 28:23 class codes
  localparam logic [5:0] CLS_ADDSUB = 6'b100010;
  localparam logic [5:0] CLS_MOVW   = 6'b100101;

  // move wide opc (bits 30:29)
  localparam logic [1:0] OPC_MOVN = 2'b00;
  localparam logic [1:0] OPC_BAD  = 2'b01;
  localparam logic [1:0] OPC_MOVZ = 2'b10;
  localparam logic [1:0] OPC_MOVK = 2'b11;

  typedef struct packed {
    logic             reg_write;
    logic [IDX_W-1:0] reg_index;
    logic [REG_W-1:0] dest_value;
    logic             flags_written;
    logic [3:0]       nzcv;
  } exec_res_t;

  typedef struct packed {
    logic             reg_we;
    logic [IDX_W-1:0] reg_idx;
    logic [REG_W-1:0] reg_data;
    logic             flags_we;
    logic [3:0]       flags;
  } wr_req_t;

endpackage

### rtl/dpi32_exec.sv
// Decode and execute for one instruction word: add/sub immediate and move wide.
// Pure combinational; depends on dpi32_pkg.
module dpi32_exec
  import dpi32_pkg::*;
(
  input  logic [31:0]      instr,
  input  logic [REG_W-1:0] rd_data,
  input  logic [3:0]       flags,
  output logic [IDX_W-1:0] rd_addr,
  output exec_res_t        res
);

  logic             sf;
  logic [5:0]       cls;
  logic [1:0]       opc;
  logic [IDX_W-1:0] rd;
  logic [IDX_W-1:0] rn;
  logic [REG_W-1:0] imm;
  logic [REG_W-1:0] opb;
  logic             is_sub;
  logic [REG_W:0]   sum;
  logic [REG_W-1:0] r;
  logic             c_flag;
  logic             v_flag;
  logic [1:0]       hw;
  logic [15:0]      imm16;
  logic [REG_W-1:0] mw_op;
  logic             wr;
  logic             fw;
  logic [REG_W-1:0] val;

  assign sf    = instr[31];
  assign cls   = instr[28:23];
  assign opc   = instr[30:29];
  assign rd    = instr[4:0];
  assign rn    = instr[9:5];
  assign hw    = instr[22:21];
  assign imm16 = instr[20:5];

  // one read port: Rn for add/sub, Rd for MOVK
  assign rd_addr = (cls == CLS_ADDSUB) ? rn : rd;

  assign imm    = instr[22] ? {8'd0, instr[21:10], 12'd0} : {20'd0, instr[21:10]};
  assign is_sub = opc[1];
  assign opb    = is_sub ? ~imm : imm;
  assign sum    = {1'b0, rd_data} + {1'b0, opb} + {{REG_W{1'b0}}, is_sub};
  assign r      = sum[REG_W-1:0];
  assign c_flag = sum[REG_W];
  assign v_flag = (rd_data[REG_W-1] == opb[REG_W-1]) && (r[REG_W-1] != rd_data[REG_W-1]);

  assign mw_op = hw[0] ? {imm16, 16'd0} : {16'd0, imm16};

  always_comb begin
    wr  = 1'b0;
    fw  = 1'b0;
    val = '0;
    if (!sf) begin
      unique case (cls)
        CLS_ADDSUB: begin
          wr  = 1'b1;
          fw  = opc[0];
          val = r;
        end
        CLS_MOVW: begin
          if (!hw[1]) begin
            unique case (opc)
              OPC_MOVN: begin
                wr  = 1'b1;
                val = ~mw_op;
              end
              OPC_MOVZ: begin
                wr  = 1'b1;
                val = mw_op;
              end
              OPC_MOVK: begin
                wr  = 1'b1;
                val = hw[0] ? {imm16, rd_data[15:0]} : {rd_data[31:16], imm16};
              end
              OPC_BAD: begin
                wr  = 1'b0;
              end
              default: begin
                wr  = 1'b0;
              end
            endcase
          end
        end
        default: begin
          wr = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    res.reg_index     = rd;
    res.reg_write     = wr && (rd != ZERO_REG);
    res.dest_value    = res.reg_write ? val : '0;
    res.flags_written = fw;
    res.nzcv          = fw ? {r[REG_W-1], (r == '0), c_flag, v_flag} : flags;
  end

endmodule

### rtl/dpi32_regfile.sv
// 31-entry general register file plus NZCV flags, one read and one write port.
// Register 31 reads as zero. Depends on dpi32_pkg.
module dpi32_regfile
  import dpi32_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [REG_W-1:0] rd_data,
  output logic [3:0]       flags,
  input  wr_req_t          wr
);

  logic [REG_W-1:0] regs_r [NUM_REGS];
  logic [3:0]       flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
      flags_r <= FLAGS_RESET;
    end else begin
      if (wr.reg_we && (wr.reg_idx != ZERO_REG)) begin
        regs_r[wr.reg_idx] <= wr.reg_data;
      end
      if (wr.flags_we) begin
        flags_r <= wr.flags;
      end
    end
  end

  assign rd_data = (rd_addr == ZERO_REG) ? '0 : regs_r[rd_addr];
  assign flags   = flags_r;

endmodule

### rtl/aarch64_dp_immediate_32_execute_core.sv
// An accepted request goes through the input register, then is executed into the
//   result register. Throughput: one request per cycle unless the output stalls.
// The register file and flags are read and written in the execute cycle, so a
//   following request sees the update with no bypass. Reset (rst_n low, sync)
//   zeroes all registers, sets flags to Z only, and empties both stages.
module aarch64_dp_immediate_32_execute_core
  import dpi32_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      in_instr_word,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_reg_write,
  output logic [IDX_W-1:0] out_reg_index,
  output logic [REG_W-1:0] out_dest_value,
  output logic             out_flags_written,
  output logic [3:0]       out_nzcv
);

`include "assert_macros.svh"

  // stage 1: captured instruction word
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [31:0] s1_instr_r;

  // stage 2: result register
  logic      out_valid_r;
  logic      out_valid_nxt;
  exec_res_t out_res_r;

  logic             in_fire;
  logic             s1_adv;
  logic [IDX_W-1:0] rf_addr;
  logic [REG_W-1:0] rf_data;
  logic [3:0]       cur_flags;
  exec_res_t        ex_res;
  wr_req_t          wr;

  // stage 1 moves on whenever the result slot is empty or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr_r <= in_instr_word;
    end
    if (s1_adv) begin
      out_res_r <= ex_res;
    end
  end

  dpi32_exec u_exec (
    .instr   (s1_instr_r),
    .rd_data (rf_data),
    .flags   (cur_flags),
    .rd_addr (rf_addr),
    .res     (ex_res)
  );

  // architectural state commits only when the request leaves stage 1
  always_comb begin
    wr.reg_we   = s1_adv && ex_res.reg_write;
    wr.reg_idx  = ex_res.reg_index;
    wr.reg_data = ex_res.dest_value;
    wr.flags_we = s1_adv && ex_res.flags_written;
    wr.flags    = ex_res.nzcv;
  end

  dpi32_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rf_addr),
    .rd_data (rf_data),
    .flags   (cur_flags),
    .wr      (wr)
  );

  assign out_valid         = out_valid_r;
  assign out_reg_write     = out_res_r.reg_write;
  assign out_reg_index     = out_res_r.reg_index;
  assign out_dest_value    = out_res_r.dest_value;
  assign out_flags_written = out_res_r.flags_written;
  assign out_nzcv          = out_res_r.nzcv;

  // a write to the zero register is never reported
  `ASSERT_NEVER(a_no_zr_write, clk, rst_n,
    out_valid_r && out_reg_write && (out_reg_index == ZERO_REG))
  // dropped writes carry a zero value
  `ASSERT_NEVER(a_nowrite_zero, clk, rst_n,
    out_valid_r && !out_reg_write && (out_dest_value != '0))
  // a stalled result blocks stage 1 from advancing
  `ASSERT_CLK(a_s1_hold, clk, rst_n,
    (s1_valid_r && out_valid_r && !out_ready) |=> (s1_valid_r && $stable(s1_instr_r)))
  // flags only change when a flag-setting op commits
  `ASSERT_CLK(a_flags_stable, clk, rst_n, !wr.flags_we |=> $stable(cur_flags))

endmodule

### tb/sv/dpi32_exec_scoreboard_pkg.sv
// Scoreboard for the 32-bit A64 data-processing-immediate execute block:
// predicts each result from the request stream and checks the results in order.
// Depends on dpi32_pkg for the result type and the encoding constants.
package dpi32_exec_scoreboard_pkg;
  import dpi32_pkg::*;

  // add/sub operation, bits 30:29 = {op, S}
  localparam logic [1:0] AS_ADD  = 2'b00;
  localparam logic [1:0] AS_ADDS = 2'b01;
  localparam logic [1:0] AS_SUB  = 2'b10;
  localparam logic [1:0] AS_SUBS = 2'b11;

  // move wide halfword select
  localparam logic [1:0] HW_LO   = 2'd0;
  localparam logic [1:0] HW_HI   = 2'd1;
  localparam logic [1:0] HW_BAD2 = 2'd2;
  localparam logic [1:0] HW_BAD3 = 2'd3;

  localparam int unsigned REPORT_LIMIT = 10;

  class exec_scoreboard;
    logic [REG_W-1:0] gpr [NUM_REGS];
    logic [3:0]       nzcv;
    exec_res_t        expected_q [$];
    int unsigned      mismatches;
    int unsigned      requests_seen;
    int unsigned      results_checked;
    int unsigned      reg_writes;
    int unsigned      flag_updates;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      nzcv            = FLAGS_RESET;
      mismatches      = 0;
      requests_seen   = 0;
      results_checked = 0;
      reg_writes      = 0;
      flag_updates    = 0;
    endfunction

    function logic [REG_W-1:0] read_gpr(logic [IDX_W-1:0] idx);
      return (idx == ZERO_REG) ? '0 : gpr[idx];
    endfunction

    // Executes one instruction word on the shadow state and queues its result.
    function void note_request(logic [31:0] word);
      exec_res_t        res;
      logic [IDX_W-1:0] rd;
      logic [1:0]       opc;
      logic [1:0]       hw;
      logic [REG_W-1:0] src;
      logic [REG_W-1:0] imm;
      logic [REG_W-1:0] mask;
      logic [REG_W:0]   wide;
      logic             does_write;
      logic             ovf;

      rd         = word[4:0];
      opc        = word[30:29];
      hw         = word[22:21];
      does_write = 1'b0;
      res        = '0;
      res.reg_index = rd;

      if (!word[31] && word[28:23] == CLS_ADDSUB) begin
        src  = read_gpr(word[9:5]);
        imm  = word[22] ? {8'h0, word[21:10], 12'h0} : {20'h0, word[21:10]};
        // subtraction as a + ~imm + 1 so that bit 32 is the A64 carry (no borrow)
        if (opc[1]) begin
          wide = {1'b0, src} + {1'b0, ~imm} + 33'd1;
          ovf  = (src[31] != imm[31]) && (wide[31] != src[31]);
        end else begin
          wide = {1'b0, src} + {1'b0, imm};
          ovf  = (src[31] == imm[31]) && (wide[31] != src[31]);
        end
        if (opc[0]) begin
          nzcv = {wide[31], wide[31:0] == '0, wide[32], ovf};
          res.flags_written = 1'b1;
          flag_updates++;
        end
        does_write     = 1'b1;
        res.dest_value = wide[31:0];
      end else if (!word[31] && word[28:23] == CLS_MOVW && opc != OPC_BAD
                   && (hw == HW_LO || hw == HW_HI)) begin
        imm  = (hw == HW_HI) ? {word[20:5], 16'h0} : {16'h0, word[20:5]};
        mask = (hw == HW_HI) ? 32'hFFFF_0000 : 32'h0000_FFFF;
        case (opc)
          OPC_MOVN: res.dest_value = ~imm;
          OPC_MOVZ: res.dest_value = imm;
          default:  res.dest_value = (read_gpr(rd) & ~mask) | imm;
        endcase
        does_write = 1'b1;
      end

      if (does_write && rd != ZERO_REG) begin
        gpr[rd]       = res.dest_value;
        res.reg_write = 1'b1;
        reg_writes++;
      end else begin
        res.dest_value = '0;
      end
      res.nzcv = nzcv;
      expected_q.push_back(res);
      requests_seen++;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    function void check_result(exec_res_t got);
      exec_res_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result #%0d with no request pending: we=%b rd=%0d val=%h fw=%b nzcv=%h",
                         results_checked, got.reg_write, got.reg_index, got.dest_value,
                         got.flags_written, got.nzcv));
        return;
      end
      want = expected_q.pop_front();
      if (got.reg_write !== want.reg_write || got.reg_index !== want.reg_index ||
          got.dest_value !== want.dest_value || got.flags_written !== want.flags_written ||
          got.nzcv !== want.nzcv) begin
        report($sformatf({"result #%0d: want we=%b rd=%0d val=%h fw=%b nzcv=%h, ",
                          "got we=%b rd=%0d val=%h fw=%b nzcv=%h"},
                         results_checked, want.reg_write, want.reg_index, want.dest_value,
                         want.flags_written, want.nzcv, got.reg_write, got.reg_index,
                         got.dest_value, got.flags_written, got.nzcv));
      end
    endfunction

    function int unsigned pending_count();
      return expected_q.size();
    endfunction
  endclass

endpackage

### tb/sv/aarch64_dp_immediate_32_execute_core_test.sv
// Self-checking test of aarch64_dp_immediate_32_execute_core: directed and random
// A64 data-processing-immediate words under four handshake idle/stall phases.
// Depends on dpi32_pkg and dpi32_exec_scoreboard_pkg.
module aarch64_dp_immediate_32_execute_core_test;
  import dpi32_pkg::*;
  import dpi32_exec_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PER_PHASE = 250;
  localparam int unsigned SETTLE_CYCLES    = 6;   // more than a request needs to pass the input and result registers

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic [31:0]      in_instr_word = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic             out_reg_write;
  logic [IDX_W-1:0] out_reg_index;
  logic [REG_W-1:0] out_dest_value;
  logic             out_flags_written;
  logic [3:0]       out_nzcv;

  // percent of cycles the sender idles / the receiver stalls
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  exec_scoreboard sb = new();

  aarch64_dp_immediate_32_execute_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_instr_word     (in_instr_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reg_write     (out_reg_write),
    .out_reg_index     (out_reg_index),
    .out_dest_value    (out_dest_value),
    .out_flags_written (out_flags_written),
    .out_nzcv          (out_nzcv)
  );

  always #1 clk = ~clk;

  // Receiver: fresh ready decision every cycle; stall_pct 0 means always ready.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: values read here are the ones from before this edge, since all
  // drivers (ours and the block's registers) update with nonblocking writes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_instr_word);
      if (out_valid && out_ready) begin
        sb.check_result('{reg_write:     out_reg_write,
                          reg_index:     out_reg_index,
                          dest_value:    out_dest_value,
                          flags_written: out_flags_written,
                          nzcv:          out_nzcv});
      end
    end
  end

  function automatic logic [31:0] enc_addsub(logic [1:0] aop, logic sh, logic [11:0] imm12,
                                             logic [4:0] rn, logic [4:0] rd);
    return {1'b0, aop, CLS_ADDSUB, sh, imm12, rn, rd};
  endfunction

  function automatic logic [31:0] enc_movw(logic [1:0] opc, logic [1:0] hw,
                                           logic [15:0] imm16, logic [4:0] rd);
    return {1'b0, opc, CLS_MOVW, hw, imm16, rd};
  endfunction

  // Mostly well-formed instructions with low register numbers favored so that
  // results feed later requests; the rest is malformed or plain noise.
  function automatic logic [31:0] random_instr();
    int unsigned pick;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [11:0] imm12;
    logic [1:0]  opc;
    logic [31:0] word;
    pick  = $urandom_range(99);
    rd    = $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom);
    rn    = $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom);
    imm12 = 12'($urandom);
    case ($urandom_range(9))
      0: imm12 = '0;
      1: imm12 = '1;
      default: ;
    endcase
    case ($urandom_range(2))
      0:       opc = OPC_MOVN;
      1:       opc = OPC_MOVZ;
      default: opc = OPC_MOVK;
    endcase
    if ($urandom_range(1))
      word = enc_addsub(2'($urandom), 1'($urandom), imm12, rn, rd);
    else
      word = enc_movw(opc, $urandom_range(1) ? HW_HI : HW_LO, 16'($urandom), rd);
    if (pick < 80) return word;                        // well-formed
    if (pick < 88) return enc_movw(2'($urandom), 2'($urandom), 16'($urandom), rd); // any opc/hw
    if (pick < 93) return word | 32'h8000_0000;        // 64-bit form, ignored
    return $urandom;
  endfunction

  // One request: optional random idle gap, then hold valid until accepted.
  task automatic send_request(input logic [31:0] word);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_instr_word <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (RANDOM_PER_PHASE) send_request(random_instr());
  endtask

  initial begin
    logic [31:0] directed [$];

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register chaining through MOVZ/MOVK, flag corners, discarded writes
    // to register 31, and examples of encodings the block must leave alone
    directed = '{
      enc_movw(OPC_MOVZ, HW_LO, 16'hFFFF, 5'd0),
      enc_movw(OPC_MOVK, HW_HI, 16'hA5A5, 5'd0),
      enc_movw(OPC_MOVK, HW_LO, 16'h0000, 5'd0),
      enc_movw(OPC_MOVN, HW_HI, 16'h8000, 5'd1),          // 0x7FFFFFFF
      enc_addsub(AS_ADDS, 1'b0, 12'd1, 5'd1, 5'd2),       // signed overflow
      enc_movw(OPC_MOVN, HW_LO, 16'h0000, 5'd5),          // all ones
      enc_addsub(AS_ADDS, 1'b0, 12'd1, 5'd5, 5'd6),       // carry out, zero
      enc_movw(OPC_MOVZ, HW_HI, 16'h8000, 5'd8),
      enc_addsub(AS_SUBS, 1'b0, 12'd1, 5'd8, 5'd9),       // overflow on subtract
      enc_addsub(AS_SUBS, 1'b0, 12'd1, ZERO_REG, 5'd3),   // borrow, negative
      enc_addsub(AS_SUBS, 1'b0, 12'd0, ZERO_REG, 5'd4),   // zero, no borrow
      enc_addsub(AS_ADD, 1'b1, 12'hFFF, 5'd5, 5'd10),
      enc_addsub(AS_SUB, 1'b1, 12'hFFF, 5'd0, 5'd11),
      enc_addsub(AS_ADDS, 1'b0, 12'hFFF, 5'd0, ZERO_REG), // flags only
      enc_movw(OPC_MOVZ, HW_LO, 16'h1234, ZERO_REG),
      enc_movw(OPC_MOVK, HW_LO, 16'h5678, ZERO_REG),
      enc_movw(OPC_BAD, HW_LO, 16'hFFFF, 5'd12),
      enc_movw(OPC_MOVZ, HW_BAD2, 16'hFFFF, 5'd13),
      enc_movw(OPC_MOVN, HW_BAD3, 16'h0000, 5'd13),
      enc_addsub(AS_ADDS, 1'b0, 12'd5, 5'd1, 5'd14) | 32'h8000_0000,
      enc_movw(OPC_MOVZ, HW_LO, 16'hBEEF, 5'd14) | 32'h8000_0000,
      32'h0000_0000,
      32'hFFFF_FFFF,
      enc_addsub(AS_SUBS, 1'b0, 12'hFFF, 5'd1, 5'd14)
    };
    foreach (directed[i]) send_request(directed[i]);

    run_phase(0, 0);
    run_phase(64, 0);
    drain();               // sender holds off until the pipe is empty
    run_phase(0, 64);
    run_phase(20, 20);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d instructions (%0d register writes, %0d flag updates)",
             sb.requests_seen, sb.reg_writes, sb.flag_updates);
    $display("over four idle/stall mixes; %0d results checked, %0d mismatches",
             sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_count() == 0)
      $display("aarch64_dp_immediate_32_execute_core: match");
    else
      $display("aarch64_dp_immediate_32_execute_core: mismatch");
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #1_000_000;
    $display("Timeout with %0d results still pending", sb.pending_count());
    $display("aarch64_dp_immediate_32_execute_core: mismatch");
    $finish;
  end

endmodule
